// ===== hw/rtl/efmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efmf_pkg
// Shared constants, types and functions for the Ethernet frame MAC filter
// and CRC-32 check.
// ----------------------------------------------------------------------------
package efmf_pkg;

	localparam int HEADER_BYTES = 14;
	localparam int FCS_BYTES    = 4;
	localparam int MIN_FRAME    = HEADER_BYTES + FCS_BYTES;

	localparam int MAC_W  = 48;
	localparam int POS_W  = 16;
	localparam int CRC_W  = 32;
	localparam int BYTE_W = 8;

	localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB88320;
	localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFFFFFF;
	localparam logic [POS_W-1:0] POS_MAX      = 16'hFFFF;

	localparam logic [MAC_W-1:0] DST_MAC_RST = 48'h80A5897841E5;
	localparam logic [MAC_W-1:0] SRC_MAC_RST = 48'h58FB84FE0DC1;

	// register indexes
	localparam logic REG_DST_MAC = 1'b0;
	localparam logic REG_SRC_MAC = 1'b1;

	// result tdata: accepted, crc_ok, runt_frame, computed_crc, zero pad
	localparam int RES_W   = 3 + CRC_W;
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef struct packed {
		logic [CRC_W-1:0] computed_crc;
		logic             runt_frame;
		logic             crc_ok;
		logic             accepted;
	} res_t;

	// reflected CRC-32, one byte
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// byte idx of a MAC, idx 0 is the most significant
	function automatic logic [BYTE_W-1:0] mac_byte(input logic [MAC_W-1:0] mac,
		input logic [2:0] idx);
		logic [BYTE_W-1:0] r;
		case (idx)
			3'd0:    r = mac[47:40];
			3'd1:    r = mac[39:32];
			3'd2:    r = mac[31:24];
			3'd3:    r = mac[23:16];
			3'd4:    r = mac[15:8];
			3'd5:    r = mac[7:0];
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/efmf_frame_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efmf_frame_check
// Per-frame state: byte position, header MAC compare, FCS delay line and
// running CRC. Produces the frame result on the last beat.
// ----------------------------------------------------------------------------
module efmf_frame_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [efmf_pkg::BYTE_W-1:0] data_byte,
	input  logic                       last_byte,
	input  logic [efmf_pkg::MAC_W-1:0] dst_mac,
	input  logic [efmf_pkg::MAC_W-1:0] src_mac,
	output efmf_pkg::res_t             res
);
	import efmf_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [CRC_W-1:0]  crc_q;
	logic [CRC_W-1:0]  tail_q;
	logic              dst_ok_q;
	logic              src_ok_q;

	logic              in_dst;
	logic              in_src;
	logic [3:0]        src_idx;
	logic              dst_ok_d;
	logic              src_ok_d;
	logic [CRC_W-1:0]  crc_d;
	logic [CRC_W-1:0]  tail_d;
	logic [CRC_W-1:0]  crc_out;
	logic              runt;

	assign in_dst  = pos_q < POS_W'(6);
	assign in_src  = !in_dst && (pos_q < POS_W'(12));
	assign src_idx = pos_q[3:0] - 4'd6;

	assign dst_ok_d = dst_ok_q && !(in_dst && (data_byte != mac_byte(dst_mac, pos_q[2:0])));
	assign src_ok_d = src_ok_q && !(in_src && (data_byte != mac_byte(src_mac, src_idx[2:0])));

	assign crc_d   = (pos_q >= POS_W'(MIN_FRAME)) ? crc_byte(crc_q, tail_q[7:0]) : crc_q;
	assign tail_d  = {data_byte, tail_q[CRC_W-1:BYTE_W]};
	assign crc_out = crc_d ^ CRC_ALL_ONES;
	// length = pos + 1
	assign runt    = pos_q < POS_W'(MIN_FRAME - 1);

	always_comb begin
		res.computed_crc = crc_out;
		res.runt_frame   = runt;
		res.crc_ok       = !runt && (crc_out == tail_d);
		res.accepted     = dst_ok_d && src_ok_d && !runt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= CRC_ALL_ONES;
			tail_q   <= '0;
			dst_ok_q <= 1'b1;
			src_ok_q <= 1'b1;
		end else if (step) begin
			if (last_byte) begin
				pos_q    <= '0;
				crc_q    <= CRC_ALL_ONES;
				tail_q   <= '0;
				dst_ok_q <= 1'b1;
				src_ok_q <= 1'b1;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				crc_q    <= crc_d;
				tail_q   <= tail_d;
				dst_ok_q <= dst_ok_d;
				src_ok_q <= src_ok_d;
			end
		end
	end

endmodule

// ===== hw/rtl/ethernet_frame_mac_filter_crc_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_frame_mac_filter_crc_check
// Receive filter: destination/source MAC match and CRC-32 check of the
// payload against the trailing FCS, one result per frame.
// ----------------------------------------------------------------------------
// Result: m_tvalid rises once the last beat has passed the input register and
//   then the result register.
// Throughput: one byte per cycle except in a stall; the CRC byte update sits
//   between the input and result registers. A last beat waits in the input
//   register while the previous result is not yet taken, which stalls the input.
// Reset: frame state cleared, MAC registers back to their defaults.
// ----------------------------------------------------------------------------
module ethernet_frame_mac_filter_crc_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tlast,   // last_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] accepted, [1] crc_ok, [2] runt_frame, [34:3] computed_crc, zero pad
	output logic [efmf_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [efmf_pkg::MAC_W-1:0]    cfg_data
);
	import efmf_pkg::*;

	logic [MAC_W-1:0]  dst_mac_q;
	logic [MAC_W-1:0]  src_mac_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	logic              m_valid_q;
	res_t              res_q;
	res_t              res;
	logic              step;

	assign step     = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_mac_q <= DST_MAC_RST;
			src_mac_q <= SRC_MAC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DST_MAC: dst_mac_q <= cfg_data;
				REG_SRC_MAC: src_mac_q <= cfg_data;
				default:     dst_mac_q <= dst_mac_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	efmf_frame_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.dst_mac   (dst_mac_q),
		.src_mac   (src_mac_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, res_q};

	// a runt frame is never accepted nor reported with a good CRC
	a_runt_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.runt_frame |-> !res_q.accepted && !res_q.crc_ok)
		else $error("runt frame flagged accepted or crc_ok");

	// a runt frame never feeds the CRC
	a_runt_crc: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.runt_frame |-> res_q.computed_crc == '0)
		else $error("runt frame with non-zero CRC");

	// a last beat blocked by a full output register is held
	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && m_valid_q && !m_tready |=> valid_s1 && last_s1)
		else $error("last beat lost while result stalled");

endmodule

// ===== verif/ethernet_frame_mac_filter_crc_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_frame_mac_filter_crc_check_tb
// Streams Ethernet frames byte by byte through the MAC filter and CRC-32
// check and compares every per-frame verdict against a cycle-free predictor.
// Covers runts, MAC mismatches, bad and good FCS, several MAC settings,
// random idling on both sides and output back-pressure that stalls the input.
// ----------------------------------------------------------------------------
module ethernet_frame_mac_filter_crc_check_tb;
	import efmf_pkg::*;

	localparam int DUT_LATENCY     = 2;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int PHASE_BYTES     = 200;

	class frame_verdicts;
		logic [MAC_W-1:0] dst_mac;
		logic [MAC_W-1:0] src_mac;
		logic [POS_W-1:0] pos;
		logic [CRC_W-1:0] crc;
		logic [CRC_W-1:0] tail;
		logic             dst_hit;
		logic             src_hit;
		res_t             verdict_q[$];
		int unsigned      faults;

		function new();
			dst_mac = DST_MAC_RST;
			src_mac = SRC_MAC_RST;
			faults  = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			pos     = '0;
			crc     = CRC_ALL_ONES;
			tail    = '0;
			dst_hit = 1'b1;
			src_hit = 1'b1;
		endfunction

		static function logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] c,
			input logic [7:0] b);
			logic [CRC_W-1:0] r;
			r = c ^ {24'h0, b};
			for (int k = 0; k < 8; k++) begin
				r = (r >> 1) ^ (CRC_POLY & {CRC_W{r[0]}});
			end
			return r;
		endfunction

		function void write_reg(input logic idx, input logic [MAC_W-1:0] value);
			case (idx)
				REG_DST_MAC: dst_mac = value;
				REG_SRC_MAC: src_mac = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		function void take_byte(input logic [7:0] b, input logic last);
			int   p;
			logic runt;
			logic [CRC_W-1:0] fcs_calc;
			res_t r;
			p = int'(pos);
			if (p < 6) begin
				if (b != dst_mac[8*(5-p) +: 8]) dst_hit = 1'b0;
			end else if (p < 12) begin
				if (b != src_mac[8*(11-p) +: 8]) src_hit = 1'b0;
			end
			// byte leaving the four-byte delay line enters the CRC past the header
			if (p >= MIN_FRAME) crc = crc_next(crc, tail[7:0]);
			tail = {b, tail[31:8]};
			if (pos != POS_MAX) pos = pos + POS_W'(1);
			if (!last) return;
			runt     = (p + 1) < MIN_FRAME;
			fcs_calc = crc ^ CRC_ALL_ONES;
			r.accepted     = dst_hit && src_hit && !runt;
			r.crc_ok       = !runt && (fcs_calc == tail);
			r.runt_frame   = runt;
			r.computed_crc = fcs_calc;
			verdict_q.push_back(r);
			clear_frame();
		endfunction

		function void check_verdict(input logic [M_TDATA_W-1:0] d);
			res_t got;
			res_t want;
			got = res_t'(d[RES_W-1:0]);
			if (verdict_q.size() == 0) begin
				$error("unexpected result beat: %h", d);
				faults++;
				return;
			end
			want = verdict_q.pop_front();
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
				faults++;
			end
			if (got.crc_ok !== want.crc_ok) begin
				$error("crc_ok: expected %0d, got %0d", want.crc_ok, got.crc_ok);
				faults++;
			end
			if (got.runt_frame !== want.runt_frame) begin
				$error("runt_frame: expected %0d, got %0d", want.runt_frame, got.runt_frame);
				faults++;
			end
			if (got.computed_crc !== want.computed_crc) begin
				$error("computed_crc: expected %h, got %h", want.computed_crc,
					got.computed_crc);
				faults++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [MAC_W-1:0]       cfg_data;

	frame_verdicts    sb = new();
	logic [MAC_W-1:0] cur_dst;
	logic [MAC_W-1:0] cur_src;
	int               bytes_sent;
	int               stall_cycles;
	bit               tx_idle_en;
	bit               rx_idle_en;
	bit               hold_off_req;

	ethernet_frame_mac_filter_crc_check i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] q[$]);
		for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
	endtask

	task automatic send_frame(input int len, input bit dst_ok, input bit src_ok,
		input bit fcs_good);
		logic [7:0]       q[$];
		logic [CRC_W-1:0] fcs;
		int               k;
		for (int i = 0; i < len; i++) begin
			if (i < 6)
				q.push_back(cur_dst[8*(5-i) +: 8]);
			else if (i < 12)
				q.push_back(cur_src[8*(11-i) +: 8]);
			else
				q.push_back(8'($urandom));
		end
		if (!dst_ok) begin
			k = $urandom_range(0, 5);
			if (k < len) q[k] ^= 8'($urandom_range(1, 255));
		end
		if (!src_ok) begin
			k = $urandom_range(6, 11);
			if (k < len) q[k] ^= 8'($urandom_range(1, 255));
		end
		if (len >= MIN_FRAME) begin
			fcs = CRC_ALL_ONES;
			for (int i = HEADER_BYTES; i < len - FCS_BYTES; i++)
				fcs = frame_verdicts::crc_next(fcs, q[i]);
			fcs ^= CRC_ALL_ONES;
			if (!fcs_good) fcs ^= 32'h1 << $urandom_range(0, 31);
			for (int i = 0; i < FCS_BYTES; i++) q[len-FCS_BYTES+i] = fcs[8*i +: 8];
		end
		send_bytes(q);
	endtask

	task automatic send_random_frame();
		int sel;
		int len;
		sel = $urandom_range(0, 19);
		if (sel < 3)
			len = $urandom_range(1, MIN_FRAME - 1);
		else if (sel < 4)
			len = MIN_FRAME;
		else if (sel < 6)
			len = $urandom_range(65, 200);
		else
			len = $urandom_range(MIN_FRAME + 1, 64);
		send_frame(len, $urandom_range(0, 6) != 0, $urandom_range(0, 6) != 0,
			$urandom_range(0, 3) != 0);
	endtask

	// drain all verdicts, let the pipe settle, then load both MAC registers
	task automatic reconfigure(input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DUT_LATENCY + 2) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DST_MAC;
		cfg_data  <= dst;
		@(negedge clk);
		cfg_index <= REG_SRC_MAC;
		cfg_data  <= src;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_dst = dst;
		cur_src = src;
	endtask

	initial begin
		int phase_end;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_DST_MAC;
		cfg_data     = '0;
		cur_dst      = DST_MAC_RST;
		cur_src      = SRC_MAC_RST;
		bytes_sent   = 0;
		stall_cycles = 0;
		tx_idle_en   = 1'b0;
		rx_idle_en   = 1'b0;
		hold_off_req = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: single-byte runt, minimum good frame, short all-zero runt
		send_bytes('{8'hFF});
		send_frame(MIN_FRAME, 1'b1, 1'b1, 1'b1);
		send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: reconfigure('0, '0);
				2: reconfigure('1, '1);
				3: reconfigure({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
				4: reconfigure('1, '0);
				default: ;
			endcase
			if (ph == 1) begin
				// output held off while short frames keep coming
				hold_off_req = 1'b1;
				repeat (40) send_frame($urandom_range(1, 20), 1'b1, 1'b1, 1'b1);
			end
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end) begin
				tx_idle_en = (ph < 3) && ($urandom_range(0, 3) != 0);
				rx_idle_en = (ph < 3) && ($urandom_range(0, 3) != 0);
				send_random_frame();
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4 * DUT_LATENCY) @(posedge clk);
		if (sb.faults == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
